FILE: src/lfbr_pkg.sv
// lfbr_pkg: shared types and constants for the lcd frame buffer refresher
// holds command codes, word structs and store geometry; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfbr_pkg;

	// command codes, also used as queued operation kinds
	localparam logic [1:0] CMD_SET     = 2'd0;
	localparam logic [1:0] CMD_CLR     = 2'd1;
	localparam logic [1:0] CMD_WIPE    = 2'd2;
	localparam logic [1:0] CMD_REFRESH = 2'd3;

	// display and store geometry
	localparam int LCD_W       = 128;
	localparam int LCD_H       = 64;
	localparam int STORE_DEPTH = 1024;
	localparam int STORE_AW    = 10;
	localparam int CURSOR_W    = 9;

	// serial framing bytes
	localparam logic [7:0] SYNC_CMD  = 8'hF8;
	localparam logic [7:0] SYNC_DATA = 8'hFA;
	localparam logic [7:0] NIB_HI    = 8'hF0;
	localparam logic [3:0] CMD_HI    = 4'h8;

	// default depth of the queue between front and back
	localparam int QDEPTH_DEF = 2;

	// input word
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] x_coord;
		logic [7:0] y_coord;
	} lfbr_in_t;

	// output word
	typedef struct packed {
		logic [7:0] serial_byte;
		logic       transaction_end;
		logic       step_last;
		logic       frame_done;
	} lfbr_out_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic [1:0]          kind;
		logic [STORE_AW-1:0] addr;
		logic [2:0]          bit_sel;
	} lfbr_op_t;

endpackage

`default_nettype wire

FILE: src/lfbr_front.sv
// lfbr_front: accepts command words, drops out-of-range pixel commands,
// and queues the rest as operations for the back end; uses lfbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfbr_front import lfbr_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire lfbr_in_t cmd,
	input  wire logic     wipe_busy,
	output logic          op_valid,
	input  wire logic     op_take,
	output lfbr_op_t      op
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	lfbr_op_t        queue_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            full;
	logic            accept;
	logic            keep;
	logic            push;
	logic            pop;
	lfbr_op_t        new_op;

	assign full      = (cnt_q == CW'(QDEPTH));
	assign cmd_stall = full | wipe_busy;
	assign accept    = cmd_valid & ~cmd_stall;

	// classify: pixel commands outside the panel are dropped here
	always_comb begin
		new_op.kind    = cmd.command;
		new_op.addr    = {cmd.y_coord[5:3], cmd.x_coord[6:0]};
		new_op.bit_sel = cmd.y_coord[2:0];
		unique case (cmd.command) inside
			CMD_SET, CMD_CLR: begin
				keep = (cmd.x_coord < 8'(LCD_W)) && (cmd.y_coord < 8'(LCD_H));
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	assign push     = accept & keep;
	assign pop      = op_take & op_valid;
	assign op_valid = (cnt_q != '0);
	assign op       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_op;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/lfbr_back.sv
// lfbr_back: frame store memory, operation sequencer and serial byte output
// executes queued operations in order; uses lfbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfbr_back import lfbr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     op_valid,
	output logic          op_take,
	input  wire lfbr_op_t op,
	output logic          wipe_busy,
	output logic          ser_valid,
	input  wire logic     ser_stall,
	output lfbr_out_t     ser
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PIX   = 3'd1;
	localparam logic [2:0] ST_WIPE  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [7:0]          mem [STORE_DEPTH];
	logic [7:0]          rd_data_q;
	logic                mem_we;
	logic                mem_re;
	logic [STORE_AW-1:0] mem_addr;
	logic [7:0]          mem_wd;

	logic [2:0]          state_q;
	lfbr_op_t            op_q;
	logic [STORE_AW-1:0] wipe_cnt_q;
	logic [3:0]          rd_idx_q;
	logic                gath_en_q;
	logic [15:0]         gath_q;
	logic [1:0]          txn_q;
	logic [1:0]          pos_q;
	logic [CURSOR_W-1:0] cursor_q;
	logic                ser_valid_q;
	lfbr_out_t           ser_q;

	logic                load_ok;
	logic [7:0]          mask;
	logic [7:0]          txn_val;
	logic [7:0]          txn_sync;
	lfbr_out_t           next_ser;

	assign wipe_busy = (state_q == ST_WIPE);
	assign op_take   = (state_q == ST_IDLE);
	assign load_ok   = ~ser_valid_q | ~ser_stall;
	assign ser_valid = ser_valid_q;
	assign ser       = ser_q;
	assign mask      = 8'd1 << op_q.bit_sel;

	// memory port control
	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = op.addr;
		mem_wd   = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = op_valid && (op.kind == CMD_SET || op.kind == CMD_CLR);
			end
			ST_PIX: begin
				mem_we   = 1'b1;
				mem_addr = op_q.addr;
				mem_wd   = (op_q.kind == CMD_SET) ? (rd_data_q | mask) : (rd_data_q & ~mask);
			end
			ST_WIPE: begin
				mem_we   = 1'b1;
				mem_addr = wipe_cnt_q;
			end
			ST_READ: begin
				mem_re   = 1'b1;
				mem_addr = {cursor_q[8:6], cursor_q[2:0], rd_idx_q};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// single-port frame store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	// transaction value and sync byte for the current output position
	always_comb begin
		case (txn_q)
			2'd0:    txn_val = {CMD_HI, 4'h0} | {3'b000, cursor_q[7:3]};
			2'd1:    txn_val = {CMD_HI, cursor_q[8], cursor_q[2:0]};
			2'd2:    txn_val = gath_q[15:8];
			default: txn_val = gath_q[7:0];
		endcase
		txn_sync = txn_q[1] ? SYNC_DATA : SYNC_CMD;
		case (pos_q)
			2'd0:    next_ser.serial_byte = txn_sync;
			2'd1:    next_ser.serial_byte = txn_val & NIB_HI;
			default: next_ser.serial_byte = {txn_val[3:0], 4'h0};
		endcase
		next_ser.transaction_end = (pos_q == 2'd2);
		next_ser.step_last       = (pos_q == 2'd2) && (txn_q == 2'd3);
		next_ser.frame_done      = next_ser.step_last && (cursor_q == '1);
	end

	// gather one pixel bit per store byte read during a refresh step
	always_ff @(posedge clk) begin
		if (gath_en_q) begin
			gath_q <= {gath_q[14:0], rd_data_q[cursor_q[5:3]]};
		end
		if (state_q == ST_IDLE) begin
			op_q <= op;
		end
		ser_q <= (state_q == ST_EMIT && load_ok) ? next_ser : ser_q;
	end

	// sequencer; reset starts with a clearing pass over the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			wipe_cnt_q  <= '0;
			rd_idx_q    <= '0;
			gath_en_q   <= 1'b0;
			txn_q       <= '0;
			pos_q       <= '0;
			cursor_q    <= '0;
			ser_valid_q <= 1'b0;
		end else begin
			gath_en_q <= (state_q == ST_READ);
			// output word valid: set on each load, cleared once taken
			if (state_q == ST_EMIT && load_ok) begin
				ser_valid_q <= 1'b1;
			end else if (ser_valid_q && !ser_stall) begin
				ser_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						case (op.kind)
							CMD_WIPE: begin
								state_q    <= ST_WIPE;
								wipe_cnt_q <= '0;
							end
							CMD_REFRESH: begin
								state_q  <= ST_READ;
								rd_idx_q <= '0;
							end
							default: begin
								state_q <= ST_PIX;
							end
						endcase
					end
				end
				ST_PIX: begin
					state_q <= ST_IDLE;
				end
				ST_WIPE: begin
					wipe_cnt_q <= wipe_cnt_q + 1'b1;
					if (wipe_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == '1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
					txn_q   <= '0;
					pos_q   <= '0;
				end
				ST_EMIT: begin
					if (load_ok) begin
						if (pos_q == 2'd2) begin
							pos_q <= '0;
							txn_q <= txn_q + 1'b1;
							if (txn_q == 2'd3) begin
								cursor_q <= cursor_q + 1'b1;
								state_q  <= ST_IDLE;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_frame_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid && ser.frame_done |-> ser.step_last)
		else $error("frame_done without step_last");
	a_step_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid && ser.step_last |-> ser.transaction_end)
		else $error("step_last not on a transaction end");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> pos_q != 2'd3)
		else $error("byte position out of range");
	a_cursor_step: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != $past(cursor_q) |-> $past(state_q == ST_EMIT))
		else $error("cursor moved outside a refresh step");
`endif

endmodule

`default_nettype wire

FILE: src/lcd_frame_buffer_refresher_core.sv
// lcd_frame_buffer_refresher_core: top level of the frame buffer refresher
// joins the command front end and the store/serial back end; uses lfbr_pkg
//
//   channel | dir | handshake            | word
//   cmd     | in  | cmd_valid/cmd_stall  | lfbr_in_t  (command, x_coord, y_coord)
//   ser     | out | ser_valid/ser_stall  | lfbr_out_t (serial byte and flags)
//
// set and clear pixel go through a read, then a write of the store byte in the back end
// a refresh step runs a dispatch, 16 store reads, a drain, then 12 output bytes
// clearing the whole store writes all 1024 store bytes, one store byte written per cycle
// after reset a clearing pass runs; cmd_stall is high until it ends
// a stalled ser holds its byte; cmd_stall rises when the operation queue is full
// or while a store clear runs
`timescale 1ns / 1ps
`default_nettype none

module lcd_frame_buffer_refresher_core import lfbr_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire lfbr_in_t cmd,
	output logic          ser_valid,
	input  wire logic     ser_stall,
	output lfbr_out_t     ser
);

	logic     op_valid;
	logic     op_take;
	lfbr_op_t op;
	logic     wipe_busy;

	// front end: accept and classify
	lfbr_front #(
		.QDEPTH(QDEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.wipe_busy (wipe_busy),
		.op_valid  (op_valid),
		.op_take   (op_take),
		.op        (op)
	);

	// back end: store and serial output
	lfbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_take   (op_take),
		.op        (op),
		.wipe_busy (wipe_busy),
		.ser_valid (ser_valid),
		.ser_stall (ser_stall),
		.ser       (ser)
	);

endmodule

`default_nettype wire
